// ===== rtl/bfc_pkg.sv =====
// Shared constants, event codes and the bitmap request type of the buddy free coalescer.
// No dependencies; every other file of the block refers to it by scoped names.

package bfc_pkg;

  localparam int MAX_PAGES_DEF  = 4096;
  localparam int NUM_ORDERS_DEF = 10;

  localparam int IDX_W  = 12;
  localparam int ORD_W  = 4;
  localparam int ZONE_W = 13;
  localparam int CNT_W  = 16;
  localparam int KIND_W = 2;

  localparam logic [ZONE_W-1:0] ZONE_RESET = 13'd4096;

  localparam logic [KIND_W-1:0] EV_BUDDY_REMOVED = 2'd0;
  localparam logic [KIND_W-1:0] EV_INSERTED      = 2'd1;
  localparam logic [KIND_W-1:0] EV_REJ_MISALIGN  = 2'd2;
  localparam logic [KIND_W-1:0] EV_REJ_PINNED    = 2'd3;

  // One access to the pair bitmap: a read, a write, or both at once.
  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
  } bmp_req_t;

endpackage

// ===== rtl/bfc_bitmap.sv =====
// Pair bitmap store of all orders below the top one, one bit per entry.
// Depends on bfc_pkg; runs a clearing pass after reset and reports ready when done.

module bfc_bitmap #(
  parameter int MAX_PAGES  = bfc_pkg::MAX_PAGES_DEF,
  parameter int NUM_ORDERS = bfc_pkg::NUM_ORDERS_DEF,
  localparam int HALF      = MAX_PAGES / 2,
  localparam int DEPTH     = (NUM_ORDERS - 1) * HALF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  bfc_pkg::bmp_req_t req,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  output logic              rdata,
  output logic              ready
);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // Clearing pass: one entry per cycle until the whole store is zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      ready    <= 1'b0;
    end else if (!ready) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        ready <= 1'b1;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[clr_addr] <= 1'b0;
    end else if (req.wr) begin
      mem[wr_addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bfc_engine.sv =====
// Sequencer and shared datapath that checks a freed block and climbs the orders.
// Depends on bfc_pkg; drives one bitmap request per cycle unless the output stalls, and holds the output register.

module bfc_engine #(
  parameter int MAX_PAGES  = bfc_pkg::MAX_PAGES_DEF,
  parameter int NUM_ORDERS = bfc_pkg::NUM_ORDERS_DEF,
  localparam int HALF      = MAX_PAGES / 2,
  localparam int HALF_W    = $clog2(HALF),
  localparam int DEPTH     = (NUM_ORDERS - 1) * HALF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bfc_pkg::IDX_W-1:0]   block_index,
  input  logic [bfc_pkg::ORD_W-1:0]   block_order,
  input  logic                        page_pinned,
  input  logic [bfc_pkg::ZONE_W-1:0]  zone_limit,
  input  logic                        bmp_ready,
  input  logic                        bmp_rdata,
  output bfc_pkg::bmp_req_t           bmp_req,
  output logic [AW-1:0]               bmp_rd_addr,
  output logic [AW-1:0]               bmp_wr_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfc_pkg::KIND_W-1:0]  event_kind,
  output logic [bfc_pkg::IDX_W-1:0]   event_index,
  output logic [bfc_pkg::ORD_W-1:0]   event_order,
  output logic [bfc_pkg::CNT_W-1:0]   free_page_count,
  output logic                        last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_TOGGLE,
    S_INSERT
  } state_t;

  localparam logic [bfc_pkg::ORD_W-1:0] ORD_TOP = bfc_pkg::ORD_W'(NUM_ORDERS - 1);

  state_t                       state;
  logic [bfc_pkg::IDX_W-1:0]    idx;
  logic [bfc_pkg::ORD_W-1:0]    ord;
  logic                         pinned;
  logic [bfc_pkg::CNT_W-1:0]    free_total;

  logic                         out_free;
  logic [bfc_pkg::ORD_W-1:0]    ord_up;
  logic [bfc_pkg::IDX_W-1:0]    idx_up;
  logic [16:0]                  buddy;
  logic                         out_of_zone;
  logic                         misaligned;
  logic                         order_bad;
  logic [bfc_pkg::CNT_W-1:0]    free_sum;
  logic                         merge;
  logic                         out_load;

  // The bit of a pair at order o sits at row o, column (i >> (o+1)) mod HALF.
  // HALF is a power of two, so the row and column simply concatenate.
  function automatic logic [AW-1:0] pair_addr(input logic [bfc_pkg::IDX_W-1:0] i,
                                              input logic [bfc_pkg::ORD_W-1:0] o);
    logic [bfc_pkg::IDX_W-1:0] sh;
    logic [HALF_W-1:0]         col;
    sh        = i >> (o + bfc_pkg::ORD_W'(1));
    col       = HALF_W'(sh);
    pair_addr = AW'({o, col});
  endfunction

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = !((state == S_IDLE) && bmp_ready);
  assign ord_up      = ord + bfc_pkg::ORD_W'(1);
  assign idx_up      = idx & ~((bfc_pkg::IDX_W'(1) << ord_up) - bfc_pkg::IDX_W'(1));
  assign buddy       = {5'd0, idx} ^ (17'd1 << ord);
  assign out_of_zone = (buddy >= {4'd0, zone_limit}) || ({1'b0, idx} >= zone_limit);
  assign misaligned  = (({4'd0, idx} & ((16'd1 << ord) - 16'd1)) != 16'd0);
  assign order_bad   = ({1'b0, ord} >= 5'(NUM_ORDERS));
  assign free_sum    = free_total + (16'd1 << ord);
  assign merge       = bmp_rdata && !out_of_zone;

  // High in every cycle that loads a new result into the output register.
  assign out_load    = out_free &&
                       ((state == S_TOGGLE) || (state == S_INSERT) ||
                        ((state == S_CHECK) &&
                         (pinned || order_bad || misaligned || ord == ORD_TOP)));

  always_comb begin
    bmp_req     = '0;
    bmp_rd_addr = pair_addr(idx, ord);
    bmp_wr_addr = pair_addr(idx, ord);
    if (state == S_CHECK && out_free && !pinned && !order_bad && !misaligned &&
        ord != ORD_TOP) begin
      bmp_req.rd = 1'b1;
    end
    if (state == S_TOGGLE && out_free) begin
      bmp_req.wr    = 1'b1;
      bmp_req.wdata = !bmp_rdata;
      if (merge && ord_up != ORD_TOP) begin
        bmp_req.rd  = 1'b1;
        bmp_rd_addr = pair_addr(idx_up, ord_up);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (!out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            idx    <= block_index;
            ord    <= block_order;
            pinned <= page_pinned;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (out_free) begin
            if (pinned || order_bad || misaligned) begin
              out_valid       <= 1'b1;
              event_kind      <= pinned ? bfc_pkg::EV_REJ_PINNED : bfc_pkg::EV_REJ_MISALIGN;
              event_index     <= idx;
              event_order     <= ord;
              free_page_count <= free_total;
              last            <= 1'b1;
              state           <= S_IDLE;
            end else begin
              free_total <= free_sum;
              if (ord == ORD_TOP) begin
                out_valid       <= 1'b1;
                event_kind      <= bfc_pkg::EV_INSERTED;
                event_index     <= idx;
                event_order     <= ord;
                free_page_count <= free_sum;
                last            <= 1'b1;
                state           <= S_IDLE;
              end else begin
                state <= S_TOGGLE;
              end
            end
          end
        end
        S_TOGGLE: begin
          // The toggle, the decision and the next order's read share this cycle.
          if (out_free) begin
            out_valid       <= 1'b1;
            free_page_count <= free_total;
            event_order     <= ord;
            if (merge) begin
              event_kind  <= bfc_pkg::EV_BUDDY_REMOVED;
              event_index <= buddy[bfc_pkg::IDX_W-1:0];
              last        <= 1'b0;
              idx         <= idx_up;
              ord         <= ord_up;
              if (ord_up == ORD_TOP) begin
                state <= S_INSERT;
              end
            end else begin
              event_kind  <= bfc_pkg::EV_INSERTED;
              event_index <= idx;
              last        <= 1'b1;
              state       <= S_IDLE;
            end
          end
        end
        S_INSERT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            event_kind      <= bfc_pkg::EV_INSERTED;
            event_index     <= idx;
            event_order     <= ord;
            free_page_count <= free_total;
            last            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/buddy_free_coalescer.sv =====
// Top level of the buddy free coalescer: zone size register, sequencer and pair bitmap.
// Depends on bfc_pkg, bfc_bitmap and bfc_engine.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------------------
//   in       | to block  | in_valid / in_stall    | block_index, block_order, page_pinned
//   out      | from block| out_valid / out_stall  | event_kind, event_index, event_order,
//            |           |                        | free_page_count, last
//   config   | to block  | zone_pages_we          | zone_pages
//
// A rejected request, or one freed at the top order, has a single result, loaded from the
// check state; an accepted one with k merges (at most NUM_ORDERS-1) gives k buddy removals
// and then its insertion, one order at a time, since each order costs one bitmap
// read-modify-write on the single port pair; no new request is taken before the last
// result is loaded. After reset the bitmap clears its (NUM_ORDERS-1)*MAX_PAGES/2 entries
// (18432 by default) while in_stall stays high; configuration writes are taken throughout.
// A stalled output holds the sequencer in place; nothing is dropped or repeated.

module buddy_free_coalescer #(
  parameter int MAX_PAGES  = bfc_pkg::MAX_PAGES_DEF,
  parameter int NUM_ORDERS = bfc_pkg::NUM_ORDERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        zone_pages_we,
  input  logic [bfc_pkg::ZONE_W-1:0]  zone_pages,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bfc_pkg::IDX_W-1:0]   block_index,
  input  logic [bfc_pkg::ORD_W-1:0]   block_order,
  input  logic                        page_pinned,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfc_pkg::KIND_W-1:0]  event_kind,
  output logic [bfc_pkg::IDX_W-1:0]   event_index,
  output logic [bfc_pkg::ORD_W-1:0]   event_order,
  output logic [bfc_pkg::CNT_W-1:0]   free_page_count,
  output logic                        last
);

  localparam int DEPTH = (NUM_ORDERS - 1) * (MAX_PAGES / 2);
  localparam int AW    = $clog2(DEPTH);

  logic [bfc_pkg::ZONE_W-1:0] zone_limit;
  bfc_pkg::bmp_req_t          bmp_req;
  logic [AW-1:0]              bmp_rd_addr;
  logic [AW-1:0]              bmp_wr_addr;
  logic                       bmp_rdata;
  logic                       bmp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_limit <= bfc_pkg::ZONE_RESET;
    end else if (zone_pages_we) begin
      zone_limit <= zone_pages;
    end
  end

  bfc_bitmap #(
    .MAX_PAGES  (MAX_PAGES),
    .NUM_ORDERS (NUM_ORDERS)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .req     (bmp_req),
    .rd_addr (bmp_rd_addr),
    .wr_addr (bmp_wr_addr),
    .rdata   (bmp_rdata),
    .ready   (bmp_ready)
  );

  bfc_engine #(
    .MAX_PAGES  (MAX_PAGES),
    .NUM_ORDERS (NUM_ORDERS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .block_index     (block_index),
    .block_order     (block_order),
    .page_pinned     (page_pinned),
    .zone_limit      (zone_limit),
    .bmp_ready       (bmp_ready),
    .bmp_rdata       (bmp_rdata),
    .bmp_req         (bmp_req),
    .bmp_rd_addr     (bmp_rd_addr),
    .bmp_wr_addr     (bmp_wr_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_kind      (event_kind),
    .event_index     (event_index),
    .event_order     (event_order),
    .free_page_count (free_page_count),
    .last            (last)
  );

`ifndef SYNTH
  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another was in work");

  // No request enters while the bitmap is still being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    !bmp_ready |-> in_stall)
    else $error("input open during the bitmap clearing pass");

  // A rejection is always the only result of its request.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == bfc_pkg::EV_REJ_PINNED ||
                  event_kind == bfc_pkg::EV_REJ_MISALIGN) |-> last)
    else $error("rejection result without last");

  // A removed buddy is always followed by more results of the same request.
  a_buddy_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == bfc_pkg::EV_BUDDY_REMOVED |-> !last)
    else $error("buddy removal marked as last result");
`endif

endmodule

// ===== test/tb_buddy_free_coalescer.sv =====
// Self-checking testbench for buddy_free_coalescer: directed table, then random free sequences.
// Depends on bfc_pkg and the buddy_free_coalescer RTL; results are checked against a local predictor.

module tb_buddy_free_coalescer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W          = bfc_pkg::IDX_W;
  localparam int ORD_W          = bfc_pkg::ORD_W;
  localparam int ZONE_W         = bfc_pkg::ZONE_W;
  localparam int CNT_W          = bfc_pkg::CNT_W;
  localparam int KIND_W         = bfc_pkg::KIND_W;

  localparam logic [KIND_W-1:0] EV_BUDDY_REMOVED = bfc_pkg::EV_BUDDY_REMOVED;
  localparam logic [KIND_W-1:0] EV_INSERTED      = bfc_pkg::EV_INSERTED;
  localparam logic [KIND_W-1:0] EV_REJ_MISALIGN  = bfc_pkg::EV_REJ_MISALIGN;
  localparam logic [KIND_W-1:0] EV_REJ_PINNED    = bfc_pkg::EV_REJ_PINNED;
  localparam logic [ZONE_W-1:0] ZONE_RESET       = bfc_pkg::ZONE_RESET;

  localparam int NUM_ORDERS     = bfc_pkg::NUM_ORDERS_DEF;
  localparam int BITS_PER_ORDER = bfc_pkg::MAX_PAGES_DEF / 2;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_REQS     = 60;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 80;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [ORD_W-1:0] order;
    logic             pinned;
  } free_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic [ORD_W-1:0]  order;
    logic [CNT_W-1:0]  count;
    logic              last;
  } free_event_t;

  typedef struct packed {
    free_req_t   req;
    logic        typed;
    free_event_t want;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                zone_pages_we;
  logic [ZONE_W-1:0]   zone_pages;
  logic                in_valid;
  logic                in_stall;
  logic [IDX_W-1:0]    block_index;
  logic [ORD_W-1:0]    block_order;
  logic                page_pinned;
  logic                out_valid;
  logic                out_stall;
  logic [KIND_W-1:0]   event_kind;
  logic [IDX_W-1:0]    event_index;
  logic [ORD_W-1:0]    event_order;
  logic [CNT_W-1:0]    free_page_count;
  logic                last;

  // Predictor state: one pair bitmap per order, the free count and the zone size.
  bit                  pair_map [NUM_ORDERS][BITS_PER_ORDER];
  logic [CNT_W-1:0]    free_total = '0;
  int unsigned         zone_bound = 4096;

  free_event_t         expected_events[$];
  free_req_t           phase_reqs[$];
  int                  mismatch_count = 0;
  bit                  sender_idle = 1'b1;
  bit                  receiver_idle = 1'b1;
  int                  long_hold_cycles = 0;

  directed_row_t directed_tab [22] = '{
    '{'{12'd0,    4'd0,  1'b1}, 1'b1, '{EV_REJ_PINNED,   12'd0,    4'd0,  16'd0,    1'b1}},
    '{'{12'd4095, 4'd15, 1'b1}, 1'b1, '{EV_REJ_PINNED,   12'd4095, 4'd15, 16'd0,    1'b1}},
    '{'{12'd0,    4'd15, 1'b0}, 1'b1, '{EV_REJ_MISALIGN, 12'd0,    4'd15, 16'd0,    1'b1}},
    '{'{12'd0,    4'd10, 1'b0}, 1'b1, '{EV_REJ_MISALIGN, 12'd0,    4'd10, 16'd0,    1'b1}},
    '{'{12'd1,    4'd1,  1'b0}, 1'b1, '{EV_REJ_MISALIGN, 12'd1,    4'd1,  16'd0,    1'b1}},
    '{'{12'd4095, 4'd9,  1'b0}, 1'b1, '{EV_REJ_MISALIGN, 12'd4095, 4'd9,  16'd0,    1'b1}},
    '{'{12'd0,    4'd9,  1'b0}, 1'b1, '{EV_INSERTED,     12'd0,    4'd9,  16'd512,  1'b1}},
    '{'{12'd512,  4'd9,  1'b0}, 1'b1, '{EV_INSERTED,     12'd512,  4'd9,  16'd1024, 1'b1}},
    '{'{12'd4095, 4'd0,  1'b0}, 1'b1, '{EV_INSERTED,     12'd4095, 4'd0,  16'd1025, 1'b1}},
    '{'{12'd4094, 4'd0,  1'b0}, 1'b0, '0},
    '{'{12'd1024, 4'd8,  1'b0}, 1'b0, '0},
    '{'{12'd1280, 4'd8,  1'b0}, 1'b0, '0},
    '{'{12'd2049, 4'd0,  1'b0}, 1'b0, '0},
    '{'{12'd2050, 4'd1,  1'b0}, 1'b0, '0},
    '{'{12'd2052, 4'd2,  1'b0}, 1'b0, '0},
    '{'{12'd2056, 4'd3,  1'b0}, 1'b0, '0},
    '{'{12'd2064, 4'd4,  1'b0}, 1'b0, '0},
    '{'{12'd2080, 4'd5,  1'b0}, 1'b0, '0},
    '{'{12'd2112, 4'd6,  1'b0}, 1'b0, '0},
    '{'{12'd2176, 4'd7,  1'b0}, 1'b0, '0},
    '{'{12'd2304, 4'd8,  1'b0}, 1'b0, '0},
    // Freeing the last page of the region merges all the way to the top order.
    '{'{12'd2048, 4'd0,  1'b0}, 1'b0, '0}
  };

  buddy_free_coalescer DUT (
    .clk             (clk),
    .rst             (rst),
    .zone_pages_we   (zone_pages_we),
    .zone_pages      (zone_pages),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .block_index     (block_index),
    .block_order     (block_order),
    .page_pinned     (page_pinned),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_kind      (event_kind),
    .event_index     (event_index),
    .event_order     (event_order),
    .free_page_count (free_page_count),
    .last            (last)
  );

  always #5 clk = ~clk;

  function automatic void post_event(logic [KIND_W-1:0] kind, int unsigned idx,
                                     int unsigned ord, logic is_last);
    free_event_t ev;
    ev.kind  = kind;
    ev.index = IDX_W'(idx);
    ev.order = ORD_W'(ord);
    ev.count = free_total;
    ev.last  = is_last;
    expected_events.push_back(ev);
  endfunction

  function automatic void predict_free(free_req_t r);
    int unsigned idx;
    int unsigned ord;
    int unsigned bit_pos;
    int unsigned buddy;
    bit          was_set;
    idx = 32'(r.index);
    ord = 32'(r.order);
    if (r.pinned) begin
      post_event(EV_REJ_PINNED, idx, ord, 1'b1);
      return;
    end
    if (ord >= NUM_ORDERS || (idx & ((1 << ord) - 1)) != 0) begin
      post_event(EV_REJ_MISALIGN, idx, ord, 1'b1);
      return;
    end
    free_total = free_total + CNT_W'(1 << ord);
    while (ord < NUM_ORDERS - 1) begin
      bit_pos = (idx >> (ord + 1)) % BITS_PER_ORDER;
      was_set = pair_map[ord][bit_pos];
      pair_map[ord][bit_pos] = !was_set;
      if (!was_set) break;
      buddy = idx ^ (1 << ord);
      if (buddy >= zone_bound || idx >= zone_bound) break;
      post_event(EV_BUDDY_REMOVED, buddy, ord, 1'b0);
      ord++;
      idx = idx & ~((1 << ord) - 1);
    end
    post_event(EV_INSERTED, idx, ord, 1'b1);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_free(free_req_t r, logic typed, free_event_t want);
    int gap;
    gap = sender_idle ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    block_index <= r.index;
    block_order <= r.order;
    page_pinned <= r.pinned;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_free(r);
    if (typed) begin
      void'(expected_events.pop_back());
      expected_events.push_back(want);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_zone(int unsigned value);
    zone_pages_we <= 1'b1;
    zone_pages    <= ZONE_W'(value);
    @(negedge clk);
    zone_pages_we <= 1'b0;
    zone_bound = value;
  endtask

  // Mostly whole aligned regions split into random sub-blocks and freed in random order,
  // so that buddies meet; the rest are random requests of any shape.
  task automatic build_phase(int count);
    free_req_t   pieces[$];
    free_req_t   pending[$];
    free_req_t   cur;
    free_req_t   tmp;
    int unsigned span;
    int unsigned k;
    int unsigned base;
    int          j;
    phase_reqs.delete();
    while (phase_reqs.size() < count) begin
      if ($urandom_range(0, 3) == 0) begin
        cur.index  = IDX_W'($urandom_range(0, 4095));
        cur.order  = ORD_W'($urandom_range(0, 15));
        cur.pinned = ($urandom_range(0, 4) == 0);
        phase_reqs.push_back(cur);
      end else begin
        k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 9);
        span = (zone_bound >= 1 && zone_bound <= 4096) ? zone_bound : 4096;
        base = ($urandom_range(0, span - 1) >> k) << k;
        pending.delete();
        pieces.delete();
        cur.index  = IDX_W'(base);
        cur.order  = ORD_W'(k);
        cur.pinned = 1'b0;
        pending.push_back(cur);
        while (pending.size() != 0) begin
          cur = pending.pop_front();
          if (cur.order > 0 && pending.size() + pieces.size() < 20 &&
              $urandom_range(0, 2) != 0) begin
            cur.order = cur.order - ORD_W'(1);
            pending.push_back(cur);
            cur.index = cur.index + IDX_W'(1 << cur.order);
            pending.push_back(cur);
          end else begin
            cur.pinned = ($urandom_range(0, 19) == 0);
            pieces.push_back(cur);
          end
        end
        for (int i = pieces.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = pieces[i];
          pieces[i] = pieces[j];
          pieces[j] = tmp;
        end
        foreach (pieces[i]) phase_reqs.push_back(pieces[i]);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned zone_plan [NUM_PHASES];
    rst           = 1'b1;
    zone_pages_we = 1'b0;
    zone_pages    = ZONE_RESET;
    in_valid      = 1'b0;
    block_index   = '0;
    block_order   = '0;
    page_pinned   = 1'b0;
    zone_plan = '{0, 1, 8191, $urandom_range(2, 4095), 4096, $urandom_range(16, 256)};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_tab[i])
      send_free(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].want);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_zone(zone_plan[p]);
      sender_idle   = (p != 3) && ($urandom_range(0, 3) != 0);
      receiver_idle = (p != 3) && ($urandom_range(0, 3) != 0);
      // Hold the output back for a long stretch so the block backs up into its input.
      if (p == 2) long_hold_cycles = LONG_HOLD;
      build_phase(PHASE_REQS);
      foreach (phase_reqs[i]) send_free(phase_reqs[i], 1'b0, '0);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("buddy_free_coalescer regression: pass");
    end else begin
      $display("buddy_free_coalescer regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    int k;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      k = receiver_idle ? $urandom_range(0, 4) : 0;
      if (long_hold_cycles > 0) begin
        k = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    free_event_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d index %0d order %0d", event_kind, event_index,
               event_order);
        mismatch_count++;
      end else begin
        want = expected_events.pop_front();
        if (event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          mismatch_count++;
        end
        if (event_index !== want.index) begin
          $error("event_index: expected %0d, got %0d", want.index, event_index);
          mismatch_count++;
        end
        if (event_order !== want.order) begin
          $error("event_order: expected %0d, got %0d", want.order, event_order);
          mismatch_count++;
        end
        if (free_page_count !== want.count) begin
          $error("free_page_count: expected %0d, got %0d", want.count, free_page_count);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("buddy_free_coalescer regression: fail");
    $finish;
  end

endmodule
